// File: rtl/dfsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfsc_pkg
// Shared types and constants for the dds frequency sweep controller.
// ----------------------------------------------------------------------------
package dfsc_pkg;

    localparam int HZ_W        = 24;
    localparam int DWELL_W     = 14;
    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int MULT_W      = 31;
    localparam int PROD_W      = 56;
    localparam int WORD_SHIFT  = 24;
    localparam int BEATS       = 5;
    localparam int BEAT_CNT_W  = 3;
    localparam int CFG_IDX_W   = 2;

    localparam logic [HZ_W-1:0]    FIXED_MAX_HZ   = 24'd9999999;
    localparam logic [MULT_W-1:0]  WORD_MULT      = 31'd1801439851;

    localparam logic [HZ_W-1:0]    START_HZ_RST   = 24'd1000;
    localparam logic [HZ_W-1:0]    END_HZ_RST     = 24'd1000000;
    localparam logic [HZ_W-1:0]    STEP_HZ_RST    = 24'd1000;
    localparam logic [DWELL_W-1:0] DWELL_MS_RST   = 14'd1;

    localparam logic [BEAT_CNT_W-1:0] LAST_BEAT   = 3'(BEATS - 1);

    typedef enum logic [1:0]
    {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_FIXED = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_START_HZ = 2'd0,
        REG_END_HZ   = 2'd1,
        REG_STEP_HZ  = 2'd2,
        REG_DWELL_MS = 2'd3
    } reg_idx_t;

endpackage

// File: rtl/dds_frequency_sweep_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_frequency_sweep_controller_top
// Fixed frequency or linear sweep control, sends tuning words as bus bytes.
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_*       in         tuser: command[1:0]; tdata: freq_hz[23:0]
//  m_*       out        tdata: data_byte[7:0]; tlast: last_byte; tuser: sweep_marker
//  cfg_*     in         cfg_index selects start, end, step, dwell; cfg_data value
//
//  a command that changes the frequency yields five output beats, one per cycle while m_tready is high,
//  and the byte serializer loads the next word only as the last beat of the word is taken
//  first beat passes through the input, frequency and serializer registers (update, multiply)
//  a tick that yields no beat does not wait on the serializer
//  rst_n clears control state and restores the register defaults at once
//  a stall on m_tready holds the beat and backs up through the stages to s_tready
// ----------------------------------------------------------------------------
module dds_frequency_sweep_controller_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // freq_hz[23:0]
    input  logic [1:0]                    s_tuser,   // command[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // data_byte[7:0]
    output logic                          m_tlast,
    output logic [0:0]                    m_tuser,   // sweep_marker
    input  logic                          cfg_we,
    input  logic [dfsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dfsc_pkg::HZ_W-1:0]     cfg_data
);

    // configuration
    logic [dfsc_pkg::HZ_W-1:0]    start_hz_reg;
    logic [dfsc_pkg::HZ_W-1:0]    end_hz_reg;
    logic [dfsc_pkg::HZ_W-1:0]    step_hz_reg;
    logic [dfsc_pkg::DWELL_W-1:0] dwell_ms_reg;

    // input stage
    logic                         in_valid_reg;
    dfsc_pkg::cmd_t               in_cmd_reg;
    logic [dfsc_pkg::HZ_W-1:0]    in_freq_reg;

    // sweep state
    logic                         sweeping_reg,  sweeping_next;
    logic [dfsc_pkg::HZ_W-1:0]    current_reg,   current_next;
    logic [dfsc_pkg::DWELL_W-1:0] tick_reg,      tick_next;
    logic                         marker_reg,    marker_next;
    logic                         emit;

    // word stage
    logic                         hz_valid_reg;
    logic [dfsc_pkg::HZ_W-1:0]    hz_reg;
    logic                         hz_marker_reg;

    // serializer
    logic                          ser_valid_reg;
    logic [dfsc_pkg::BEAT_CNT_W-1:0] ser_cnt_reg;
    logic [dfsc_pkg::WORD_W-1:0]   ser_word_reg;
    logic                          ser_marker_reg;

    logic                          ser_load_ok;
    logic                          hz_free;
    logic                          in_move;
    logic                          out_fire;
    logic [dfsc_pkg::PROD_W-1:0]   product;
    logic [dfsc_pkg::DWELL_W-1:0]  tick_inc;
    logic [dfsc_pkg::HZ_W:0]       step_sum;

    assign out_fire    = ser_valid_reg && m_tready;
    assign ser_load_ok = !ser_valid_reg || (m_tready && ser_cnt_reg == dfsc_pkg::LAST_BEAT);
    assign hz_free     = !hz_valid_reg || ser_load_ok;
    assign in_move     = in_valid_reg && (!emit || hz_free);
    assign s_tready    = !in_valid_reg || in_move;

    assign tick_inc = tick_reg + dfsc_pkg::DWELL_W'(1);
    assign step_sum = {1'b0, current_reg} + {1'b0, step_hz_reg};

    always_comb
    begin
        sweeping_next = sweeping_reg;
        current_next  = current_reg;
        tick_next     = tick_reg;
        marker_next   = marker_reg;
        emit          = 1'b0;
        case (in_cmd_reg)
            dfsc_pkg::CMD_TICK:
            begin
                if (sweeping_reg)
                begin
                    if (tick_inc < dwell_ms_reg)
                    begin
                        tick_next = tick_inc;
                    end
                    else
                    begin
                        emit        = 1'b1;
                        marker_next = !marker_reg;
                        tick_next   = '0;
                        if (step_sum > {1'b0, end_hz_reg})
                            current_next = start_hz_reg;
                        else
                            current_next = step_sum[dfsc_pkg::HZ_W-1:0];
                    end
                end
            end
            dfsc_pkg::CMD_START:
            begin
                emit          = 1'b1;
                sweeping_next = 1'b1;
                tick_next     = '0;
                current_next  = start_hz_reg;
            end
            dfsc_pkg::CMD_FIXED:
            begin
                emit          = 1'b1;
                sweeping_next = 1'b0;
                tick_next     = '0;
                current_next  = (in_freq_reg > dfsc_pkg::FIXED_MAX_HZ) ?
                                dfsc_pkg::FIXED_MAX_HZ : in_freq_reg;
            end
            default:
            begin
                emit          = 1'b1;
                sweeping_next = 1'b0;
                tick_next     = '0;
                current_next  = '0;
            end
        endcase
    end

    assign product = dfsc_pkg::PROD_W'(hz_reg) * dfsc_pkg::PROD_W'(dfsc_pkg::WORD_MULT);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_hz_reg <= dfsc_pkg::START_HZ_RST;
            end_hz_reg   <= dfsc_pkg::END_HZ_RST;
            step_hz_reg  <= dfsc_pkg::STEP_HZ_RST;
            dwell_ms_reg <= dfsc_pkg::DWELL_MS_RST;
        end
        else if (cfg_we)
        begin
            case (dfsc_pkg::reg_idx_t'(cfg_index))
                dfsc_pkg::REG_START_HZ: start_hz_reg <= cfg_data;
                dfsc_pkg::REG_END_HZ:   end_hz_reg   <= cfg_data;
                dfsc_pkg::REG_STEP_HZ:  step_hz_reg  <= cfg_data;
                dfsc_pkg::REG_DWELL_MS: dwell_ms_reg <= cfg_data[dfsc_pkg::DWELL_W-1:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            sweeping_reg  <= 1'b0;
            current_reg   <= '0;
            tick_reg      <= '0;
            marker_reg    <= 1'b0;
            hz_valid_reg  <= 1'b0;
            ser_valid_reg <= 1'b0;
            ser_cnt_reg   <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;

            if (in_move)
            begin
                sweeping_reg <= sweeping_next;
                current_reg  <= current_next;
                tick_reg     <= tick_next;
                marker_reg   <= marker_next;
            end

            if (hz_free)
                hz_valid_reg <= in_move && emit;

            if (ser_load_ok)
            begin
                ser_valid_reg <= hz_valid_reg;
                ser_cnt_reg   <= '0;
            end
            else if (out_fire)
            begin
                ser_cnt_reg <= ser_cnt_reg + dfsc_pkg::BEAT_CNT_W'(1);
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            in_cmd_reg  <= dfsc_pkg::cmd_t'(s_tuser);
            in_freq_reg <= s_tdata;
        end
        if (hz_free)
        begin
            hz_reg        <= current_next;
            hz_marker_reg <= marker_next;
        end
        if (ser_load_ok)
        begin
            ser_word_reg   <= product[dfsc_pkg::WORD_SHIFT +: dfsc_pkg::WORD_W];
            ser_marker_reg <= hz_marker_reg;
        end
    end

    // byte select, control byte first then msb to lsb
    always_comb
    begin
        case (ser_cnt_reg)
            3'd1:    m_tdata = ser_word_reg[31:24];
            3'd2:    m_tdata = ser_word_reg[23:16];
            3'd3:    m_tdata = ser_word_reg[15:8];
            3'd4:    m_tdata = ser_word_reg[7:0];
            default: m_tdata = '0;
        endcase
    end

    assign m_tvalid   = ser_valid_reg;
    assign m_tlast    = (ser_cnt_reg == dfsc_pkg::LAST_BEAT);
    assign m_tuser[0] = ser_marker_reg;

endmodule

// File: rtl/dfsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfsc_checker
// Port level checks for the dds frequency sweep controller.
// ----------------------------------------------------------------------------
module dfsc_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [23:0]                    s_tdata,
    input  logic [1:0]                     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [7:0]                     m_tdata,
    input  logic                           m_tlast,
    input  logic [0:0]                     m_tuser,
    input  logic                           cfg_we,
    input  logic [dfsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dfsc_pkg::HZ_W-1:0]      cfg_data
);

    // a word keeps going until its last beat
    a_word_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("word broken off before its last beat");

    // marker is the same on every beat of a word
    a_marker_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> $stable(m_tuser))
        else $error("marker changed inside a word");

    // a word right after another opens with the control byte
    a_control_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid || m_tdata == 8'd0))
        else $error("word does not open with control byte");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled beat changed");

endmodule

bind dds_frequency_sweep_controller_top dfsc_checker u_dfsc_checker (.*);
